>>> hw/rtl/vdes_pkg.sv
// vdes_pkg: shared types, constants and helper functions of the directory entry scanner
// depends on nothing, used by vfat_directory_entry_scanner_top
package vdes_pkg;

    localparam int ENTRY_BITS     = 256;
    localparam int UNITS_PER_SLOT = 13;
    localparam int ROW_BITS       = UNITS_PER_SLOT * 16;
    localparam int IN_DATA_BITS   = 272;
    localparam int OUT_DATA_BITS  = 168;
    localparam int CFG_IDX_BITS   = 2;

    localparam logic [7:0] ATTR_LONG   = 8'h0F;
    localparam logic [7:0] FREE_MARK   = 8'hE5;
    localparam logic [7:0] KANJI_LEAD  = 8'h05;
    localparam logic [7:0] SLOT_ID_MSK = 8'hBF;
    localparam logic [7:0] CHR_DOT     = 8'h2E;
    localparam logic [7:0] CHR_SPACE   = 8'h20;
    localparam int         ATTR_HIDDEN = 1;
    localparam int         ATTR_VOLUME = 3;
    localparam int         SLOT_LAST   = 6;

    // reciprocal of 13 scaled by 2^15, exact for 9-bit operands
    localparam logic [20:0] RECIP13     = 21'd2521;
    localparam int          RECIP_SHIFT = 15;

    localparam logic ACT_ENTRY   = 1'b0;
    localparam logic ACT_READ    = 1'b1;
    localparam logic KIND_RECORD = 1'b0;
    localparam logic KIND_UNIT   = 1'b1;

    localparam logic [CFG_IDX_BITS-1:0] REG_VFAT_ENABLE  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_HIDDEN_DOT   = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_PREFER_SHORT = 2'd2;

    typedef logic [4:0] t_offs;
    localparam t_offs UNIT_OFFS [UNITS_PER_SLOT] = '{
        5'd1, 5'd3, 5'd5, 5'd7, 5'd9, 5'd14, 5'd16, 5'd18, 5'd20, 5'd22, 5'd24, 5'd28, 5'd30
    };

    typedef struct packed {
        logic [15:0] record_start;
        logic [4:0]  slot_total;
        logic        has_long_name;
        logic [8:0]  long_unit_count;
        logic [63:0] short_name_lo;
        logic [39:0] short_name_hi;
        logic [3:0]  short_length;
        logic [7:0]  entry_attributes;
    } t_rec;

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r = c + 8'd32;
        end
        return r;
    endfunction

    function automatic logic [7:0] rot_add(input logic [7:0] sum, input logic [7:0] c);
        return {sum[0], sum[7:1]} + c;
    endfunction

endpackage

>>> hw/rtl/vfat_directory_entry_scanner_top.sv
// vfat_directory_entry_scanner_top: directory entry scanner with long-name slot store
// depends on vdes_pkg
//
// Usage:
// - slave stream takes one transaction per 32-byte directory entry (tuser = 0) or per
//   long-name unit read (tuser = 1, unit index in tdata)
// - master stream gives at most one result per input transaction, in input order;
//   skipped entries and long-name slots give none
// - configuration writes (index 0 vfat_enable, 1 hidden_dot, 2 prefer_short) are taken
//   every cycle and belong to idle periods of the stream
// - three register stages: input register, parse/store stage, output register;
//   each result passes through them in that order
// - one transaction per cycle sustained while the output is not stalled; the slot store is
//   one row of 13 units per slot, written whole and read into stage 2 by the parse stage
// - each stage moves when the one after it is empty or moving, so input is still taken
//   while a result waits, until the earlier stages fill; a stalled output holds its data
// - synchronous reset clears the chain state, entry counter, stage valids and sets the
//   registers to vfat_enable 1, hidden_dot 0, prefer_short 0; the unit store keeps its
//   contents and a never-written unit reads as an unspecified value
module vfat_directory_entry_scanner_top
    import vdes_pkg::*;
#(
    parameter int MAX_SLOTS     = 20,
    parameter int POSITION_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_s_tvalid,
    output logic                     o_s_tready,
    // entry_word0, entry_word1, entry_word2, entry_word3, unit_index, zero pad
    input  logic [IN_DATA_BITS-1:0]  i_s_tdata,
    // action
    input  logic                     i_s_tuser,
    output logic                     o_m_tvalid,
    input  logic                     i_m_tready,
    // record_start, slot_total, has_long_name, long_unit_count, short_name_lo,
    // short_name_hi, short_length, entry_attributes, name_unit, zero pad
    output logic [OUT_DATA_BITS-1:0] o_m_tdata,
    // result_kind
    output logic                     o_m_tuser,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic                     i_cfg_data
);

    localparam int SW = $clog2(MAX_SLOTS + 1);
    localparam int RW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

    // configuration
    logic r_vfat_enable, r_hidden_dot, r_prefer_short;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vfat_enable  <= 1'b1;
            r_hidden_dot   <= 1'b0;
            r_prefer_short <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_VFAT_ENABLE:  r_vfat_enable  <= i_cfg_data;
                REG_HIDDEN_DOT:   r_hidden_dot   <= i_cfg_data;
                REG_PREFER_SHORT: r_prefer_short <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stage flow
    logic r_v1, r_v2, r_v3;
    logic en1, en2, en3, fire1;

    assign en3        = !r_v3 || i_m_tready;
    assign en2        = !r_v2 || en3;
    assign en1        = !r_v1 || en2;
    assign o_s_tready = en1;
    assign fire1      = r_v1 && en2;

    // input register, alias checksum over the first six name bytes taken here
    logic [ENTRY_BITS-1:0] r_w1;
    logic [8:0]            r_idx1;
    logic                  r_act1;
    logic [7:0]            r_psum1;
    logic [7:0]            psum;

    always_comb begin
        psum = '0;
        for (int i = 0; i < 6; i++) begin
            psum = rot_add(psum, i_s_tdata[8*i +: 8]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en1) begin
            r_v1 <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1 && i_s_tvalid) begin
            r_w1    <= i_s_tdata[ENTRY_BITS-1:0];
            r_idx1  <= i_s_tdata[ENTRY_BITS +: 9];
            r_act1  <= i_s_tuser;
            r_psum1 <= psum;
        end
    end

    // chain state
    logic                     r_phase, n_phase;
    logic [SW-1:0]            r_chain, n_chain;
    logic [SW-1:0]            r_next, n_next;
    logic [7:0]               r_csum, n_csum;
    logic [POSITION_BITS-1:0] r_pos, n_pos;

    logic [7:0] b0, attr, b13, sl8, sum;
    logic       is_free, start_ok, do_start, do_common, cand;
    logic       wr_en, wr_zero;
    logic [RW-1:0] wr_slot;
    logic [RW:0]   zrow;
    logic [SW-1:0] longs;

    assign b0   = r_w1[7:0];
    assign attr = r_w1[8*11 +: 8];
    assign b13  = r_w1[8*13 +: 8];
    assign sl8  = b0 & SLOT_ID_MSK;
    assign is_free  = (b0 == 8'h00) || (b0 == FREE_MARK);
    assign start_ok = b0[SLOT_LAST] && (sl8 != 8'd0) && (sl8 <= 8'(MAX_SLOTS));

    always_comb begin
        sum = r_psum1;
        for (int i = 6; i < 11; i++) begin
            sum = rot_add(sum, r_w1[8*i +: 8]);
        end
    end

    always_comb begin
        n_phase   = r_phase;
        n_chain   = r_chain;
        n_next    = r_next;
        n_csum    = r_csum;
        n_pos     = r_pos;
        wr_en     = 1'b0;
        wr_slot   = '0;
        cand      = 1'b0;
        longs     = '0;
        do_start  = 1'b0;
        do_common = 1'b0;
        if (fire1 && r_act1 == ACT_ENTRY) begin
            n_pos = r_pos + POSITION_BITS'(1);
            if (!r_vfat_enable) begin
                n_phase = 1'b0;
                cand    = !attr[ATTR_VOLUME] && !is_free;
            end else if (r_phase && r_next != '0) begin
                if (attr == ATTR_LONG) begin
                    if (sl8 != 8'(r_next) || b13 != r_csum) begin
                        do_start = 1'b1;
                    end else begin
                        wr_en   = 1'b1;
                        wr_slot = RW'(r_next - SW'(1));
                        n_next  = r_next - SW'(1);
                    end
                end else begin
                    n_phase   = 1'b0;
                    do_common = 1'b1;
                end
            end else if (r_phase) begin
                n_phase = 1'b0;
                if (b0 != FREE_MARK) begin
                    if (attr == ATTR_LONG) begin
                        do_start = 1'b1;
                    end else if (!is_free && !attr[ATTR_VOLUME]) begin
                        cand  = 1'b1;
                        longs = (sum == r_csum) ? r_chain : '0;
                    end
                end
            end else begin
                do_common = 1'b1;
            end
            if (do_common && b0 != FREE_MARK) begin
                if (attr == ATTR_LONG) begin
                    do_start = 1'b1;
                end else if (!attr[ATTR_VOLUME] && !is_free) begin
                    cand = 1'b1;
                end
            end
            if (do_start) begin
                n_phase = 1'b0;
                if (start_ok) begin
                    n_chain = SW'(sl8);
                    n_csum  = b13;
                    n_next  = SW'(sl8 - 8'd1);
                    n_phase = 1'b1;
                    wr_en   = 1'b1;
                    wr_slot = RW'(sl8 - 8'd1);
                end
            end
        end
    end

    assign wr_zero = wr_en && b0[SLOT_LAST];
    assign zrow    = {1'b0, wr_slot} + (RW+1)'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 1'b0;
            r_chain <= '0;
            r_next  <= '0;
            r_csum  <= '0;
            r_pos   <= '0;
        end else begin
            r_phase <= n_phase;
            r_chain <= n_chain;
            r_next  <= n_next;
            r_csum  <= n_csum;
            r_pos   <= n_pos;
        end
    end

    // slot store: one row per slot, plus a flag per row for a zeroed first unit
    logic [ROW_BITS-1:0]  r_mem [MAX_SLOTS];
    logic [MAX_SLOTS-1:0] r_zero;
    logic [ROW_BITS-1:0]  wr_row;

    always_comb begin
        for (int u = 0; u < UNITS_PER_SLOT; u++) begin
            wr_row[16*u +: 16] = r_w1[8*int'(UNIT_OFFS[u]) +: 16];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_slot]  <= wr_row;
            r_zero[wr_slot] <= 1'b0;
        end
        if (wr_zero && zrow < (RW+1)'(MAX_SLOTS)) begin
            r_zero[zrow[RW-1:0]] <= 1'b1;
        end
    end

    // read address split into row and unit within row
    logic [20:0]   prod;
    logic [5:0]    rd_row6;
    logic [8:0]    rd_rem;
    logic          rd_ok;
    logic [RW-1:0] rd_addr;

    assign prod    = 21'(r_idx1) * RECIP13;
    assign rd_row6 = prod[RECIP_SHIFT +: 6];
    assign rd_rem  = r_idx1 - 9'(rd_row6) * 9'd13;
    assign rd_ok   = 7'(rd_row6) < 7'(MAX_SLOTS);
    assign rd_addr = rd_ok ? rd_row6[RW-1:0] : '0;

    // short name formatting
    logic [7:0] nx [12];
    logic [7:0] ex [3];
    logic [7:0] bx [13];
    logic [7:0] ox [13];
    logic       nv, ev, dot;
    logic [3:0] nl, el, flen, slen, dd;
    logic [7:0] c;

    always_comb begin
        nv = 1'b1;
        nl = '0;
        for (int i = 0; i < 12; i++) begin
            nx[i] = 8'h00;
        end
        for (int i = 0; i < 8; i++) begin
            c  = to_lower(r_w1[8*i +: 8]);
            if (c == KANJI_LEAD) begin
                c = FREE_MARK;
            end
            nv    = nv && (r_w1[8*i +: 8] != 8'h00);
            nx[i] = c;
            if (nv && c != CHR_SPACE) begin
                nl = 4'(i + 1);
            end
        end
        ev = 1'b1;
        el = '0;
        for (int k = 0; k < 3; k++) begin
            c     = to_lower(r_w1[8*(8+k) +: 8]);
            ev    = ev && (c != 8'h00);
            ex[k] = c;
            if (ev && c != CHR_SPACE) begin
                el = 4'(k + 1);
            end
        end
        flen = (el != '0) ? nl + 4'd1 + el : nl;
        dot  = attr[ATTR_HIDDEN] && r_hidden_dot;
        slen = flen + 4'(dot);
        bx[12] = 8'h00;
        for (int p = 0; p < 12; p++) begin
            dd    = 4'(p) - nl - 4'd1;
            bx[p] = 8'h00;
            if (4'(p) < nl) begin
                bx[p] = nx[p];
            end else if (el != '0 && 4'(p) == nl) begin
                bx[p] = CHR_DOT;
            end else if (el != '0 && 4'(p) > nl && 4'(p) <= nl + el) begin
                case (dd[1:0])
                    2'd0:    bx[p] = ex[0];
                    2'd1:    bx[p] = ex[1];
                    2'd2:    bx[p] = ex[2];
                    default: bx[p] = 8'h00;
                endcase
            end
        end
        ox[0] = dot ? CHR_DOT : bx[0];
        for (int j = 1; j < 13; j++) begin
            ox[j] = dot ? bx[j-1] : bx[j];
        end
    end

    // record fields
    t_rec                     rec;
    logic [POSITION_BITS-1:0] start_pos;
    logic [31:0]              start_ext;
    logic [7:0]               total_ext;
    logic [15:0]              count_ext;
    logic                     has_long;

    assign start_pos = r_pos - POSITION_BITS'(longs);
    assign start_ext = 32'(start_pos);
    assign total_ext = 8'(longs) + 8'd1;
    assign count_ext = 16'(longs) * 16'd13;
    assign has_long  = (longs != '0) && !r_prefer_short;

    always_comb begin
        rec.record_start     = start_ext[15:0];
        rec.slot_total       = total_ext[4:0];
        rec.has_long_name    = has_long;
        rec.long_unit_count  = has_long ? count_ext[8:0] : 9'd0;
        rec.short_name_lo    = {ox[7], ox[6], ox[5], ox[4], ox[3], ox[2], ox[1], ox[0]};
        rec.short_name_hi    = {ox[12], ox[11], ox[10], ox[9], ox[8]};
        rec.short_length     = slen;
        rec.entry_attributes = attr;
    end

    // stage 2
    t_rec                r_rec2;
    logic                r_kind2;
    logic [ROW_BITS-1:0] r_row2;
    logic [3:0]          r_col2;
    logic                r_rdok2;
    logic                r_z2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en2) begin
            r_v2 <= fire1 && (r_act1 == ACT_READ || (cand && flen != '0));
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire1) begin
            r_kind2 <= (r_act1 == ACT_READ) ? KIND_UNIT : KIND_RECORD;
            r_rec2  <= rec;
            r_row2  <= r_mem[rd_addr];
            r_z2    <= r_zero[rd_addr];
            r_col2  <= rd_rem[3:0];
            r_rdok2 <= rd_ok;
        end
    end

    // stage 3, output register
    logic [15:0] unit;
    t_rec        rec_out;

    always_comb begin
        unit = '0;
        for (int u = 0; u < UNITS_PER_SLOT; u++) begin
            if (r_col2 == 4'(u)) begin
                unit = r_row2[16*u +: 16];
            end
        end
        if (!r_rdok2 || (r_col2 == 4'd0 && r_z2)) begin
            unit = '0;
        end
        rec_out = (r_kind2 == KIND_RECORD) ? r_rec2 : '0;
        if (r_kind2 == KIND_RECORD) begin
            unit = '0;
        end
    end

    logic [OUT_DATA_BITS-1:0] r_out_data;
    logic                     r_out_user;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (en3) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3 && r_v2) begin
            r_out_user <= r_kind2;
            r_out_data <= {5'd0, unit, rec_out.entry_attributes, rec_out.short_length,
                           rec_out.short_name_hi, rec_out.short_name_lo,
                           rec_out.long_unit_count, rec_out.has_long_name,
                           rec_out.slot_total, rec_out.record_start};
        end
    end

    assign o_m_tvalid = r_v3;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;

endmodule
